// File: sv/wbps_pkg.sv
// Shared types, codes and character helpers for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN_DEF = 128;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int CMD_W          = 2;
   localparam int STATUS_W       = 3;
   localparam int MATCH_OFFSET_W = 32;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_READY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SINGLE   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADHEX   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_TOOLONG  = 3'd6;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd7;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_QMARK    = 8'h3F;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_F  = 8'h46;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP    = 8'd32;
   localparam logic [7:0] DIGIT_BASE  = 8'd48;
   localparam logic [7:0] LETTER_BASE = 8'd55;

   typedef struct packed {
      logic clear;
      logic write;
      logic shift;
   } cell_ctl_type;

   function automatic logic [7:0] upper_of(input logic [7:0] c);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         return c - CASE_GAP;
      end
      return c;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] u;
      u = upper_of(c);
      return (u >= CH_DIGIT_0 && u <= CH_DIGIT_9) || (u >= CH_UPPER_A && u <= CH_UPPER_F);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] d;
      u = upper_of(c);
      if (u >= CH_DIGIT_0 && u <= CH_DIGIT_9) begin
         d = u - DIGIT_BASE;
      end else begin
         d = u - LETTER_BASE;
      end
      return d[3:0];
   endfunction

endpackage

// File: sv/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: text parser, scan control and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  command, text_char, scan_byte, last_byte
//   rsp      out        rsp_valid / rsp_stall  status, match_offset
//
// One word per cycle sustained while rsp_stall is low; a taken word passes the input register,
// then the result register, before its result leaves. The cycle is set by the per-element byte
// compare across all pattern cells and the select at the pattern length.
// Synchronous reset clears flags, length, held digit, offset and the prefix-match bits;
// pattern storage is not cleared. rsp_stall holds the result register and backs up
// into req_stall in the same cycle when the input register is full.
module wildcard_byte_pattern_scanner #(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wbps_pkg::CMD_W-1:0]          req_command,
   input  logic [7:0]                          req_text_char,
   input  logic [7:0]                          req_scan_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wbps_pkg::STATUS_W-1:0]       rsp_status,
   output logic [wbps_pkg::MATCH_OFFSET_W-1:0] rsp_match_offset
);
   import wbps_pkg::*;

   localparam int IDX_W  = $clog2(MAX_PATTERN);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int WIDE_A = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
   localparam int WIDE_W = (WIDE_A > MATCH_OFFSET_W) ? WIDE_A : MATCH_OFFSET_W;

   logic             in_valid_ff;
   logic [CMD_W-1:0] in_command_ff;
   logic [7:0]       in_text_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [MATCH_OFFSET_W-1:0] rsp_offset_ff;

   logic [LEN_W-1:0]       length_ff, length_in;
   logic                   held_valid_ff, held_valid_in;
   logic [7:0]             held_char_ff, held_char_in;
   logic                   ready_ff, ready_in;
   logic                   error_ff, error_in;
   logic                   over_ff, over_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   logic                   exec;
   logic                   take;
   logic [STATUS_W-1:0]    status_in;
   logic [WIDE_W-1:0]      where;
   cell_ctl_type           cell_ctl;
   logic                   do_append;
   logic [7:0]             app_value;
   logic                   app_wild;
   logic                   cell_hit;

   logic                   room;
   logic [LEN_W-1:0]       append_len;
   logic                   too_long;
   logic [OFFSET_BITS-1:0] count;
   logic [WIDE_W-1:0]      count_w;
   logic [WIDE_W-1:0]      len_w;
   logic                   len_zero;
   logic                   scan_hit;
   logic [WIDE_W-1:0]      hit_where;
   logic                   pair_single;
   logic                   pair_bad;
   logic [7:0]             pair_value;

   assign exec      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !exec;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (exec) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_command_ff <= req_command;
         in_text_ff    <= req_text_char;
         in_byte_ff    <= req_scan_byte;
         in_last_ff    <= req_last_byte;
      end
   end

   assign room       = length_ff < LEN_W'(MAX_PATTERN);
   assign append_len = room ? length_ff + LEN_W'(1) : length_ff;
   assign too_long   = append_len >= LEN_W'(MAX_PATTERN);

   assign pair_single = (in_text_ff == CH_NUL) || (in_text_ff == CH_QMARK)
                        || (in_text_ff == CH_SPACE);
   assign pair_bad    = !is_hex(held_char_ff) || !is_hex(in_text_ff);
   assign pair_value  = {hex_value(held_char_ff), hex_value(in_text_ff)};

   assign count     = (offset_ff != '1) ? offset_ff + OFFSET_BITS'(1) : offset_ff;
   assign count_w   = WIDE_W'(count);
   assign len_w     = WIDE_W'(length_ff);
   assign len_zero  = (length_ff == '0);
   assign scan_hit  = len_zero || ((count_w >= len_w) && cell_hit);
   assign hit_where = len_zero ? WIDE_W'(offset_ff) : count_w - len_w;

   always_comb begin
      status_in     = ST_REJECTED;
      where         = '0;
      length_in     = length_ff;
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      ready_in      = ready_ff;
      error_in      = error_ff;
      over_in       = over_ff;
      offset_in     = offset_ff;
      cell_ctl      = '0;
      do_append     = 1'b0;
      app_value     = '0;
      app_wild      = 1'b0;
      unique case (in_command_ff)
         CMD_CLEAR: begin
            length_in     = '0;
            held_valid_in = 1'b0;
            held_char_in  = '0;
            ready_in      = 1'b0;
            error_in      = 1'b0;
            over_in       = 1'b0;
            offset_in     = '0;
            cell_ctl.clear = 1'b1;
            status_in     = ST_ACCEPTED;
         end
         CMD_TEXT: begin
            if (!ready_ff && !error_ff) begin
               if (held_valid_ff) begin
                  held_valid_in = 1'b0;
                  held_char_in  = '0;
                  if (pair_single) begin
                     error_in  = 1'b1;
                     status_in = ST_SINGLE;
                  end else if (pair_bad) begin
                     error_in  = 1'b1;
                     status_in = ST_BADHEX;
                  end else begin
                     do_append = 1'b1;
                     app_value = pair_value;
                  end
               end else if (in_text_ff == CH_SPACE) begin
                  status_in = ST_ACCEPTED;
               end else if (in_text_ff == CH_NUL) begin
                  ready_in  = 1'b1;
                  status_in = ST_READY;
               end else if (in_text_ff == CH_QMARK) begin
                  do_append = 1'b1;
                  app_wild  = 1'b1;
               end else begin
                  held_valid_in = 1'b1;
                  held_char_in  = in_text_ff;
                  status_in     = ST_ACCEPTED;
               end
            end
         end
         CMD_SCAN: begin
            if (ready_ff && !error_ff && !over_ff) begin
               cell_ctl.shift = 1'b1;
               offset_in      = count;
               if (scan_hit) begin
                  over_in   = 1'b1;
                  status_in = ST_MATCH;
                  where     = hit_where;
               end else if (in_last_ff) begin
                  over_in   = 1'b1;
                  status_in = ST_NOMATCH;
               end else begin
                  status_in = ST_ACCEPTED;
               end
            end
         end
         default: begin
            status_in = ST_REJECTED;
         end
      endcase
      if (do_append) begin
         cell_ctl.write = room;
         length_in      = append_len;
         if (too_long) begin
            error_in  = 1'b1;
            status_in = ST_TOOLONG;
         end else begin
            status_in = ST_ACCEPTED;
         end
      end
      if (!exec) begin
         cell_ctl = '0;
      end
   end

   wbps_match_cells #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_cells (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cell_ctl),
      .wr_index  (IDX_W'(length_ff)),
      .wr_value  (app_value),
      .wr_wild   (app_wild),
      .scan_byte (in_byte_ff),
      .sel_index (IDX_W'(length_ff - LEN_W'(1))),
      .hit       (cell_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         held_valid_ff <= 1'b0;
         held_char_ff  <= '0;
         ready_ff      <= 1'b0;
         error_ff      <= 1'b0;
         over_ff       <= 1'b0;
         offset_ff     <= '0;
      end else if (exec) begin
         length_ff     <= length_in;
         held_valid_ff <= held_valid_in;
         held_char_ff  <= held_char_in;
         ready_ff      <= ready_in;
         error_ff      <= error_in;
         over_ff       <= over_in;
         offset_ff     <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_status_ff <= status_in;
         rsp_offset_ff <= where[MATCH_OFFSET_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_offset = rsp_offset_ff;

   assert property (@(posedge clock) disable iff (reset) exec |=> rsp_valid)
      else $error("executed word produced no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MATCH) |-> over_ff)
      else $error("match reported without scan over");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_match_offset != '0) |-> (rsp_status == ST_MATCH))
      else $error("nonzero offset on a non-match result");

   assert property (@(posedge clock) disable iff (reset) !(ready_ff && error_ff))
      else $error("pattern both ready and in error");

   assert property (@(posedge clock) disable iff (reset) over_ff |-> ready_ff)
      else $error("scan over without a ready pattern");

endmodule

// File: sv/wbps_match_cells.sv
// Pattern element cells with a running prefix-match bit per element.
module wbps_match_cells #(
   parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wbps_pkg::cell_ctl_type         ctl,
   input  logic [$clog2(MAX_PATTERN)-1:0] wr_index,
   input  logic [7:0]                     wr_value,
   input  logic                           wr_wild,
   input  logic [7:0]                     scan_byte,
   input  logic [$clog2(MAX_PATTERN)-1:0] sel_index,
   output logic                           hit
);
   import wbps_pkg::*;

   logic [7:0]             pat_ff [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] wild_ff;
   logic [MAX_PATTERN-1:0] eq;
   logic [MAX_PATTERN-1:0] prefix_ff;
   logic [MAX_PATTERN-1:0] prefix_in;

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         pat_ff[wr_index]  <= wr_value;
         wild_ff[wr_index] <= wr_wild;
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         eq[j] = wild_ff[j] || (pat_ff[j] == scan_byte);
      end
   end

   // element j matches when the byte fits and elements below matched one byte earlier
   assign prefix_in = eq & {prefix_ff[MAX_PATTERN-2:0], 1'b1};
   assign hit       = prefix_in[sel_index];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         prefix_ff <= '0;
      end else if (ctl.shift) begin
         prefix_ff <= prefix_in;
      end
   end

endmodule
